### sv/ascon_pkg.sv
// Shared types, constants and helpers for the Ascon permutation unit.
// Used by ascon_ctrl, ascon_round and ascon_permutation_unit; no dependencies.
package ascon_pkg;

  localparam int LANE_W       = 64;
  localparam int LANES        = 5;
  localparam int CNT_W        = 5;
  localparam int IDX_W        = 4;
  localparam int SCHEDULE_LEN = 16;
  localparam int MAX_ROUNDS_DEFAULT = 16;

  typedef logic [LANES-1:0][LANE_W-1:0] state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ctrl_state_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic             load;
    logic             step;
    logic [IDX_W-1:0] idx;
  } ctrl_t;

  // Round constant for schedule entry idx: high nibble 3 - idx, low nibble 12 + idx.
  function automatic logic [7:0] round_const(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] lo;
    hi = IDX_W'(4'h3 - idx);
    lo = IDX_W'(4'hc + idx);
    return {hi, lo};
  endfunction

endpackage

### sv/ascon_round.sv
// One Ascon round: constant addition, bitsliced S-box and linear layer.
// Depends on ascon_pkg; reused once per cycle by the permutation unit.
module ascon_round
  import ascon_pkg::*;
(
  input  state_t           s_i,
  input  logic [IDX_W-1:0] idx,
  output state_t           s_o
);

  function automatic logic [LANE_W-1:0] rotr(input logic [LANE_W-1:0] x, input int r);
    return (x >> r) | (x << (LANE_W - r));
  endfunction

  logic [LANE_W-1:0] a0, a1, a2, a3, a4;
  logic [LANE_W-1:0] b0, b1, b2, b3, b4;
  logic [LANE_W-1:0] c0, c1, c2, c3, c4;

  always_comb begin
    // Constant addition and the input XORs of the S-box.
    a0 = s_i[0] ^ s_i[4];
    a1 = s_i[1];
    a2 = (s_i[2] ^ LANE_W'(round_const(idx))) ^ s_i[1];
    a3 = s_i[3];
    a4 = s_i[4] ^ s_i[3];

    // Chi-like core.
    b0 = a0 ^ (~a1 & a2);
    b1 = a1 ^ (~a2 & a3);
    b2 = a2 ^ (~a3 & a4);
    b3 = a3 ^ (~a4 & a0);
    b4 = a4 ^ (~a0 & a1);

    // Output XORs and complement of lane 2.
    c0 = b0 ^ b4;
    c1 = b1 ^ b0;
    c2 = ~b2;
    c3 = b3 ^ b2;
    c4 = b4;

    s_o[0] = c0 ^ rotr(c0, 19) ^ rotr(c0, 28);
    s_o[1] = c1 ^ rotr(c1, 61) ^ rotr(c1, 39);
    s_o[2] = c2 ^ rotr(c2, 1)  ^ rotr(c2, 6);
    s_o[3] = c3 ^ rotr(c3, 10) ^ rotr(c3, 17);
    s_o[4] = c4 ^ rotr(c4, 7)  ^ rotr(c4, 41);
  end

endmodule

### sv/ascon_ctrl.sv
// Round sequencer for the Ascon permutation unit: handshakes, round count
// and schedule index. Depends on ascon_pkg.
module ascon_ctrl
  import ascon_pkg::*;
#(
  parameter int MAX_ROUNDS = MAX_ROUNDS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CNT_W-1:0] num_rounds,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             bad_rounds,
  output ctrl_t            ctl
);

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             bad_r, bad_nxt;
  logic             bad_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign bad_req = (num_rounds == '0) || (num_rounds > CNT_W'(MAX_ROUNDS));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    bad_nxt   = bad_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    ctl.load  = 1'b0;
    ctl.step  = 1'b0;
    ctl.idx   = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load = 1'b1;
          bad_nxt  = bad_req;
          // The last n rounds of the schedule start at entry 16 - n.
          idx_nxt  = IDX_W'(CNT_W'(SCHEDULE_LEN) - num_rounds);
          cnt_nxt  = num_rounds - CNT_W'(1);
          state_nxt = bad_req ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        idx_nxt  = idx_r + IDX_W'(1);
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign bad_rounds = bad_r;

endmodule

### sv/ascon_permutation_unit.sv
// Ascon-p permutation unit: applies the last num_rounds (1 to MAX_ROUNDS) rounds
// of the 16-round schedule to a 320-bit state given as five 64-bit lane words.
// A single round circuit is reused once per clock, so a word is loaded, goes through
// its rounds and then waits in the output register until taken. The input is
// stalled from acceptance until the result has been taken. A round count of zero
// or above MAX_ROUNDS sets bad_rounds and presents the unchanged state in the cycle
// after acceptance. Nothing is kept between words.
module ascon_permutation_unit
  import ascon_pkg::*;
#(
  parameter int MAX_ROUNDS = MAX_ROUNDS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [LANE_W-1:0] in_word0,
  input  logic [LANE_W-1:0] in_word1,
  input  logic [LANE_W-1:0] in_word2,
  input  logic [LANE_W-1:0] in_word3,
  input  logic [LANE_W-1:0] in_word4,
  input  logic [CNT_W-1:0]  in_num_rounds,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LANE_W-1:0] out_word0,
  output logic [LANE_W-1:0] out_word1,
  output logic [LANE_W-1:0] out_word2,
  output logic [LANE_W-1:0] out_word3,
  output logic [LANE_W-1:0] out_word4,
  output logic              out_bad_rounds
);

  ctrl_t  ctl;
  state_t state_r, state_nxt;
  state_t round_out;

  ascon_ctrl #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .num_rounds(in_num_rounds),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bad_rounds(out_bad_rounds),
    .ctl       (ctl)
  );

  ascon_round u_round (
    .s_i(state_r),
    .idx(ctl.idx),
    .s_o(round_out)
  );

  always_comb begin
    state_nxt = state_r;
    if (ctl.load) begin
      state_nxt = {in_word4, in_word3, in_word2, in_word1, in_word0};
    end else if (ctl.step) begin
      state_nxt = round_out;
    end
  end

  // State words are payload only and need no reset.
  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign out_word0 = state_r[0];
  assign out_word1 = state_r[1];
  assign out_word2 = state_r[2];
  assign out_word3 = state_r[3];
  assign out_word4 = state_r[4];

endmodule
